// ----- rtl/core/aac_pkg.sv -----
// Shared types and constants for the averaged affine axis correction block.
// Used by the channel interfaces, the accumulator, the row lanes and the top level.
// No dependencies.
package aac_pkg;

  // Field widths
  localparam int RAW_W     = 16;
  localparam int CEN_W     = 17;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 33;
  localparam int ROWSUM_W  = 35;
  localparam int OUT_W     = 22;
  localparam int FRAC_BITS = 12;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS = 2'd3;

  // Register reset values: identity matrix in Q4.12, zero offsets
  localparam logic [CFG_W-1:0] ROW0_RESET    = 48'h0000_0000_1000;
  localparam logic [CFG_W-1:0] ROW1_RESET    = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] ROW2_RESET    = 48'h1000_0000_0000;
  localparam logic [CFG_W-1:0] OFFSETS_RESET = 48'h0000_0000_0000;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [CEN_W-1:0] centered_t;
  typedef logic signed [OUT_W-1:0] corrected_t;

  // Mean minus offset, one element per axis
  typedef struct packed {
    centered_t x;
    centered_t y;
    centered_t z;
  } centered_vec_t;

  // Stage load strobes from the top level to each row lane
  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/aac_channels.sv -----
// Valid/ready channel interfaces for raw samples and corrected vectors.
// Depends on aac_pkg for the field types.
interface aac_sample_if;
  logic          valid;
  logic          ready;
  aac_pkg::raw_t raw_x;
  aac_pkg::raw_t raw_y;
  aac_pkg::raw_t raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface aac_result_if;
  logic                valid;
  logic                ready;
  aac_pkg::corrected_t corrected_x;
  aac_pkg::corrected_t corrected_y;
  aac_pkg::corrected_t corrected_z;

  modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
                  input ready);
  modport sink (input valid, input corrected_x, input corrected_y, input corrected_z,
                output ready);
endinterface

// ----- rtl/core/aac_accum.sv -----
// Window accumulator: sums samples per axis, takes the floor mean at window end
// and registers mean minus offset. Depends on aac_pkg and aac_sample_if.
module aac_accum #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  aac_sample_if.sink                  samples,
  input  logic [aac_pkg::CFG_W-1:0]   offsets,
  input  logic                        next_free,
  output aac_pkg::centered_vec_t      centered,
  output logic                        centered_valid
);

  localparam int SUM_W = aac_pkg::RAW_W + AVG_SHIFT;
  localparam int CNT_W = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'((1 << AVG_SHIFT) - 1);

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic [CNT_W-1:0]        samples_taken;
  aac_pkg::raw_t           mean_x, mean_y, mean_z;
  aac_pkg::raw_t           off_x, off_y, off_z;
  logic                    take;
  logic                    closing;

  // Accept whenever the centered register is empty or moving on
  assign samples.ready = !centered_valid || next_free;
  assign take          = samples.valid && samples.ready;
  assign closing       = (samples_taken == LAST);

  // Running sums including the item at the port
  assign sum_x_next = sum_x + SUM_W'(samples.raw_x);
  assign sum_y_next = sum_y + SUM_W'(samples.raw_y);
  assign sum_z_next = sum_z + SUM_W'(samples.raw_z);

  // Floor mean by arithmetic shift
  assign mean_x = aac_pkg::RAW_W'(sum_x_next >>> AVG_SHIFT);
  assign mean_y = aac_pkg::RAW_W'(sum_y_next >>> AVG_SHIFT);
  assign mean_z = aac_pkg::RAW_W'(sum_z_next >>> AVG_SHIFT);

  assign off_x = offsets[15:0];
  assign off_y = offsets[31:16];
  assign off_z = offsets[47:32];

  // Advance the window count and sums; clear them when the window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      samples_taken <= '0;
    end else if (take) begin
      if (closing) begin
        sum_x         <= '0;
        sum_y         <= '0;
        sum_z         <= '0;
        samples_taken <= '0;
      end else begin
        sum_x         <= sum_x_next;
        sum_y         <= sum_y_next;
        sum_z         <= sum_z_next;
        samples_taken <= samples_taken + CNT_W'(1);
      end
    end
  end

  // Hold the centered vector until the lanes take it
  always_ff @(posedge clk) begin
    if (rst) begin
      centered_valid <= 1'b0;
    end else if (take && closing) begin
      centered_valid <= 1'b1;
    end else if (next_free) begin
      centered_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && closing) begin
      centered.x <= {mean_x[15], mean_x} - {off_x[15], off_x};
      centered.y <= {mean_y[15], mean_y} - {off_y[15], off_y};
      centered.z <= {mean_z[15], mean_z} - {off_z[15], off_z};
    end
  end

endmodule

// ----- rtl/core/aac_row_lane.sv -----
// One matrix row: three registered Q4.12 products, then row sum shifted right 12.
// Depends on aac_pkg.
module aac_row_lane (
  input  logic                       clk,
  input  aac_pkg::lane_ctrl_t        ctrl,
  input  logic [aac_pkg::CFG_W-1:0]  coeffs,
  input  aac_pkg::centered_vec_t     centered,
  output aac_pkg::corrected_t        result
);

  logic signed [aac_pkg::COEF_W-1:0]   coef0, coef1, coef2;
  logic signed [aac_pkg::PROD_W-1:0]   prod0, prod1, prod2;
  logic signed [aac_pkg::ROWSUM_W-1:0] row_sum;

  assign coef0 = coeffs[15:0];
  assign coef1 = coeffs[31:16];
  assign coef2 = coeffs[47:32];

  // Products, one per column
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod0 <= aac_pkg::PROD_W'(coef0) * aac_pkg::PROD_W'(centered.x);
      prod1 <= aac_pkg::PROD_W'(coef1) * aac_pkg::PROD_W'(centered.y);
      prod2 <= aac_pkg::PROD_W'(coef2) * aac_pkg::PROD_W'(centered.z);
    end
  end

  assign row_sum = {{2{prod0[aac_pkg::PROD_W-1]}}, prod0}
                 + {{2{prod1[aac_pkg::PROD_W-1]}}, prod1}
                 + {{2{prod2[aac_pkg::PROD_W-1]}}, prod2};

  // Floor shift by the fraction bits, keep the result width
  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      result <= row_sum[aac_pkg::FRAC_BITS +: aac_pkg::OUT_W];
    end
  end

endmodule

// ----- rtl/core/averaged_affine_axis_correction_top.sv -----
// Averaged affine three-axis correction, top level.
// Throughput: one sample item per cycle while the output is not stalled; one result per
// 2^AVG_SHIFT samples. A window's last sample reaches the output through the centered
// register, the product stage and the row-sum output register in each row lane.
// Reset (rst, synchronous): empty pipeline, zero sums and count, identity matrix,
// zero offsets. Depends on aac_pkg, aac_channels, aac_accum, aac_row_lane.
module averaged_affine_axis_correction_top #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  aac_sample_if.sink                      samples,
  aac_result_if.source                    corrected,
  input  logic                            cfg_we,
  input  logic [aac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aac_pkg::CFG_W-1:0]       cfg_data
);

  logic [aac_pkg::CFG_W-1:0] row0_coefficients;
  logic [aac_pkg::CFG_W-1:0] row1_coefficients;
  logic [aac_pkg::CFG_W-1:0] row2_coefficients;
  logic [aac_pkg::CFG_W-1:0] axis_offsets;

  aac_pkg::centered_vec_t centered_vec;
  logic                   centered_valid;
  logic                   prod_valid;
  logic                   out_free;
  logic                   prod_free;
  aac_pkg::lane_ctrl_t    lane_ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_coefficients <= aac_pkg::ROW0_RESET;
      row1_coefficients <= aac_pkg::ROW1_RESET;
      row2_coefficients <= aac_pkg::ROW2_RESET;
      axis_offsets      <= aac_pkg::OFFSETS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aac_pkg::REG_ROW0:    row0_coefficients <= cfg_data;
        aac_pkg::REG_ROW1:    row1_coefficients <= cfg_data;
        aac_pkg::REG_ROW2:    row2_coefficients <= cfg_data;
        aac_pkg::REG_OFFSETS: axis_offsets      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage flow: each stage moves on when the next is empty or moving
  assign out_free  = !corrected.valid || corrected.ready;
  assign prod_free = !prod_valid || out_free;

  assign lane_ctrl.prod_load = centered_valid && prod_free;
  assign lane_ctrl.sum_load  = prod_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid      <= 1'b0;
      corrected.valid <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= centered_valid;
      end
      if (out_free) begin
        corrected.valid <= prod_valid;
      end
    end
  end

  aac_accum #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples),
    .offsets        (axis_offsets),
    .next_free      (prod_free),
    .centered       (centered_vec),
    .centered_valid (centered_valid)
  );

  // One lane per matrix row; their output registers form the result item
  aac_row_lane u_lane_x (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .coeffs   (row0_coefficients),
    .centered (centered_vec),
    .result   (corrected.corrected_x)
  );

  aac_row_lane u_lane_y (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .coeffs   (row1_coefficients),
    .centered (centered_vec),
    .result   (corrected.corrected_y)
  );

  aac_row_lane u_lane_z (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .coeffs   (row2_coefficients),
    .centered (centered_vec),
    .result   (corrected.corrected_z)
  );

endmodule

// ----- tb/averaged_affine_axis_correction_checker.sv -----
`timescale 1ns / 100ps
// Checker for the averaged affine axis correction block: watches both channels and the
// register port, predicts each corrected vector and compares it. Depends on aac_pkg, aac_channels.
module averaged_affine_axis_correction_checker #(
  parameter int AVG_SHIFT = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  aac_sample_if                         samples,
  aac_result_if                         corrected,
  input  logic                          cfg_we,
  input  logic [aac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aac_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_checked
);
  import aac_pkg::*;

  localparam int unsigned WINDOW_LAST = (1 << AVG_SHIFT) - 1;

  typedef struct packed {
    corrected_t x;
    corrected_t y;
    corrected_t z;
  } corrected_vec_t;

  // Mirror of the block's registers and window state
  logic [CFG_W-1:0]   row_coef [3];
  logic [CFG_W-1:0]   offsets;
  logic signed [23:0] acc_x, acc_y, acc_z;
  int unsigned        window_fill;
  corrected_vec_t     expected_vectors [$];

  // Signed Q4.12 coefficient or signed integer offset from one 16-bit lane of a packed register
  function automatic longint lane(input logic [CFG_W-1:0] word, input int idx);
    return longint'($signed(word[16*idx +: 16]));
  endfunction

  // One output component: row times centered mean, floor-shifted by the fraction bits
  function automatic corrected_t row_component(input logic [CFG_W-1:0] row,
                                               input longint cx, input longint cy,
                                               input longint cz);
    longint total;
    total = lane(row, 0) * cx + lane(row, 1) * cy + lane(row, 2) * cz;
    return corrected_t'(total >>> FRAC_BITS);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    corrected_vec_t want;
    longint sx, sy, sz, cx, cy, cz;
    if (rst) begin
      row_coef[0] = ROW0_RESET;
      row_coef[1] = ROW1_RESET;
      row_coef[2] = ROW2_RESET;
      offsets = OFFSETS_RESET;
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      window_fill = 0;
      expected_vectors.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      // Compare an accepted result with the oldest expected vector
      if (corrected.valid && corrected.ready) begin
        if (expected_vectors.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d, %0d) with nothing expected",
                                    corrected.corrected_x, corrected.corrected_y,
                                    corrected.corrected_z));
        end else begin
          want = expected_vectors.pop_front();
          if (corrected.corrected_x !== want.x)
            report_mismatch($sformatf("vector %0d x: got %0d, expected %0d",
                                      results_checked, corrected.corrected_x, want.x));
          if (corrected.corrected_y !== want.y)
            report_mismatch($sformatf("vector %0d y: got %0d, expected %0d",
                                      results_checked, corrected.corrected_y, want.y));
          if (corrected.corrected_z !== want.z)
            report_mismatch($sformatf("vector %0d z: got %0d, expected %0d",
                                      results_checked, corrected.corrected_z, want.z));
          results_checked++;
        end
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW0:    row_coef[0] = cfg_data;
          REG_ROW1:    row_coef[1] = cfg_data;
          REG_ROW2:    row_coef[2] = cfg_data;
          REG_OFFSETS: offsets = cfg_data;
          default: ;
        endcase
      end

      // Accumulate an accepted sample; close the window on its last one
      if (samples.valid && samples.ready) begin
        sx = longint'(acc_x) + longint'(samples.raw_x);
        sy = longint'(acc_y) + longint'(samples.raw_y);
        sz = longint'(acc_z) + longint'(samples.raw_z);
        if (window_fill != WINDOW_LAST) begin
          acc_x = sx[23:0];
          acc_y = sy[23:0];
          acc_z = sz[23:0];
          window_fill++;
        end else begin
          cx = (sx >>> AVG_SHIFT) - lane(offsets, 0);
          cy = (sy >>> AVG_SHIFT) - lane(offsets, 1);
          cz = (sz >>> AVG_SHIFT) - lane(offsets, 2);
          want.x = row_component(row_coef[0], cx, cy, cz);
          want.y = row_component(row_coef[1], cx, cy, cz);
          want.z = row_component(row_coef[2], cx, cy, cz);
          expected_vectors.push_back(want);
          acc_x = '0;
          acc_y = '0;
          acc_z = '0;
          window_fill = 0;
        end
      end
    end
    outstanding = expected_vectors.size();
  end

endmodule

// ----- tb/averaged_affine_axis_correction_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the averaged affine axis correction block: clock, reset, sample
// stimulus, register writes and verdict. Depends on aac_pkg, aac_channels and the checker.
module averaged_affine_axis_correction_top_test;
  import aac_pkg::*;

  localparam int AVG_SHIFT    = 3;
  localparam int WINDOW       = 1 << AVG_SHIFT;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 83;

  localparam raw_t RAW_MAX = 16'sh7FFF;
  localparam raw_t RAW_MIN = -16'sd32768;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   samples_sent = 0;
  int                   cycle_count = 0;
  int                   mismatches;
  int                   outstanding;
  int                   results_checked;

  aac_sample_if samples ();
  aac_result_if corrected ();

  averaged_affine_axis_correction_top #(
    .AVG_SHIFT(AVG_SHIFT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .corrected(corrected),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  averaged_affine_axis_correction_checker #(
    .AVG_SHIFT(AVG_SHIFT)
  ) vector_check (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .corrected(corrected),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vectors still expected", cycle_count, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: stall at random at the current rate
  initial begin
    corrected.ready = 1'b0;
    forever begin
      @(negedge clk);
      corrected.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Raw sample biased toward the rails
  function automatic raw_t pick_raw();
    case ($urandom_range(7))
      0: return RAW_MAX;
      1: return RAW_MIN;
      default: return raw_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_register();
    return CFG_W'({$urandom, $urandom});
  endfunction

  // Offer one sample item, idling first at the current rate, and hold it until taken
  task automatic send_sample(input raw_t x, input raw_t y, input raw_t z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid = 1'b0;
      samples.raw_x = raw_t'($urandom);
      @(negedge clk);
    end
    samples.valid = 1'b1;
    samples.raw_x = x;
    samples.raw_y = y;
    samples.raw_z = z;
    do @(posedge clk); while (!samples.ready);
    samples_sent++;
  endtask

  // Drop valid, wait until every expected vector is out, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    samples.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase: reconfigure while idle, then stream samples
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [CFG_W-1:0] row0, input logic [CFG_W-1:0] row1,
                           input logic [CFG_W-1:0] row2, input logic [CFG_W-1:0] offs,
                           input bit pause_mid);
    wait_drained();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_register(REG_ROW0, row0);
    write_register(REG_ROW1, row1);
    write_register(REG_ROW2, row2);
    write_register(REG_OFFSETS, offs);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (pause_mid && n == PHASE_ITEMS / 2) wait_drained();
      send_sample(pick_raw(), pick_raw(), pick_raw());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ROW0;
    cfg_data = '0;
    samples.valid = 1'b0;
    samples.raw_x = '0;
    samples.raw_y = '0;
    samples.raw_z = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity matrix after reset; x mean of alternating rails floors to -1
    for (int i = 0; i < WINDOW; i++)
      send_sample((i % 2 != 0) ? RAW_MIN : RAW_MAX, RAW_MAX, RAW_MIN);

    // Most negative coefficients and offsets against full-scale positive samples
    wait_drained();
    write_register(REG_ROW0, 48'h8000_8000_8000);
    write_register(REG_ROW1, 48'h8000_8000_8000);
    write_register(REG_ROW2, 48'h8000_8000_8000);
    write_register(REG_OFFSETS, 48'h8000_8000_8000);
    for (int i = 0; i < WINDOW; i++)
      send_sample(RAW_MAX, RAW_MAX, RAW_MAX);

    // Most positive coefficients; change the offsets halfway through the window
    wait_drained();
    write_register(REG_ROW0, 48'h7FFF_7FFF_7FFF);
    write_register(REG_ROW1, 48'h7FFF_7FFF_7FFF);
    write_register(REG_ROW2, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < WINDOW / 2; i++)
      send_sample(RAW_MIN, RAW_MIN, RAW_MIN);
    wait_drained();
    write_register(REG_OFFSETS, 48'h7FFF_7FFF_7FFF);
    for (int i = WINDOW / 2; i < WINDOW; i++)
      send_sample(RAW_MIN, RAW_MIN, RAW_MIN);

    // Random phases under different flow control
    run_phase(0, 0, random_register(), random_register(), random_register(),
              random_register(), 1'b0);
    run_phase(79, 0, random_register(), random_register(), random_register(),
              random_register(), 1'b1);
    run_phase(0, 79, random_register(), random_register(), random_register(),
              random_register(), 1'b0);
    run_phase(15, 15, random_register(), random_register(), random_register(),
              random_register(), 1'b0);
    run_phase(0, 0, ROW0_RESET, ROW1_RESET, ROW2_RESET, OFFSETS_RESET, 1'b0);

    wait_drained();
    $display("Sent %0d sample items, checked %0d corrected vectors in %0d cycles",
             samples_sent, results_checked, cycle_count);
    $display("Windows of %0d samples; matrices from identity to full-scale extremes", WINDOW);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
